### src/hlcc_pkg.sv
// Shared types, register indexes and the duty table for the heater level cook controller.
package hlcc_pkg;

  typedef struct packed {
    logic [3:0] buttons_pressed;
    logic       tick;
  } in_item_t;

  typedef struct packed {
    logic [2:0] level_leds;
    logic       heater_on;
    logic       heater_idle_lamp;
    logic       cooking;
  } out_item_t;

  typedef struct packed {
    logic [7:0] cook_seconds;
    logic [6:0] hold_repeat_ticks;
    logic [6:0] ticks_per_second;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    PRESS_NONE  = 3'd0,
    PRESS_UP    = 3'd1,
    PRESS_DOWN  = 3'd2,
    PRESS_STOP  = 3'd3,
    PRESS_START = 3'd4
  } press_t;

  typedef enum logic {
    PH_SELECT = 1'b0,
    PH_COOK   = 1'b1
  } phase_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_COOK_SECONDS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_REPEAT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND  = 2'd2;

  localparam logic [7:0] COOK_SECONDS_RST      = 8'd16;
  localparam logic [6:0] HOLD_REPEAT_TICKS_RST = 7'd100;
  localparam logic [6:0] TICKS_PER_SECOND_RST  = 7'd100;

  localparam logic [2:0] LEVEL_MAX = 3'd7;

  // On-count of the heater window for each power level.
  function automatic logic [6:0] duty_on(input logic [2:0] lv);
    logic [6:0] r;
    case (lv)
      3'd1:    r = 7'd10;
      3'd2:    r = 7'd20;
      3'd3:    r = 7'd40;
      3'd4:    r = 7'd25;
      3'd5:    r = 7'd35;
      3'd6:    r = 7'd45;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // Period of the heater window for each power level.
  function automatic logic [6:0] duty_period(input logic [2:0] lv);
    logic [6:0] r;
    case (lv)
      3'd1, 3'd2, 3'd3: r = 7'd100;
      3'd4, 3'd5, 3'd6: r = 7'd50;
      default:          r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

### src/hlcc_cfg.sv
// Configuration register file for the heater level cook controller.
module hlcc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hlcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hlcc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output hlcc_pkg::cfg_regs_t                 regs
);

  hlcc_pkg::cfg_regs_t regs_r, regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        hlcc_pkg::CFG_COOK_SECONDS:      regs_nxt.cook_seconds      = cfg_data;
        hlcc_pkg::CFG_HOLD_REPEAT_TICKS: regs_nxt.hold_repeat_ticks = cfg_data[6:0];
        hlcc_pkg::CFG_TICKS_PER_SECOND:  regs_nxt.ticks_per_second  = cfg_data[6:0];
        default:                         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.cook_seconds      <= hlcc_pkg::COOK_SECONDS_RST;
      regs_r.hold_repeat_ticks <= hlcc_pkg::HOLD_REPEAT_TICKS_RST;
      regs_r.ticks_per_second  <= hlcc_pkg::TICKS_PER_SECOND_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

### src/hlcc_engine.sv
// Controller state and its one-item update: button latch, tick counters, phase and heater window.
module hlcc_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  hlcc_pkg::in_item_t   item,
  input  hlcc_pkg::cfg_regs_t  regs,
  output hlcc_pkg::out_item_t  result
);

  logic [3:0]       prev_btn_r, prev_btn_nxt;
  hlcc_pkg::press_t latch_r, latch_nxt;
  logic [6:0]       hold_r, hold_nxt;
  logic [2:0]       level_r, level_nxt;
  hlcc_pkg::phase_t phase_r, phase_nxt;
  logic [6:0]       pwm_r, pwm_nxt;
  logic [6:0]       presc_r, presc_nxt;
  logic [7:0]       secs_r, secs_nxt;
  logic [1:0]       lamps_r, lamps_nxt;

  logic [3:0] fresh;
  logic [6:0] on_cnt;
  logic [6:0] period;

  assign fresh  = (item.buttons_pressed ^ prev_btn_r) & item.buttons_pressed;
  assign on_cnt = hlcc_pkg::duty_on(level_r);
  assign period = hlcc_pkg::duty_period(level_r);

  always_comb begin
    prev_btn_nxt = prev_btn_r;
    latch_nxt    = latch_r;
    hold_nxt     = hold_r;
    level_nxt    = level_r;
    phase_nxt    = phase_r;
    pwm_nxt      = pwm_r;
    presc_nxt    = presc_r;
    secs_nxt     = secs_r;
    lamps_nxt    = lamps_r;

    // A button change latches the highest newly pressed button, or clears the latch.
    if (item.buttons_pressed != prev_btn_r) begin
      prev_btn_nxt = item.buttons_pressed;
      if (fresh[3])      latch_nxt = hlcc_pkg::PRESS_START;
      else if (fresh[2]) latch_nxt = hlcc_pkg::PRESS_STOP;
      else if (fresh[1]) latch_nxt = hlcc_pkg::PRESS_DOWN;
      else if (fresh[0]) latch_nxt = hlcc_pkg::PRESS_UP;
      else               latch_nxt = hlcc_pkg::PRESS_NONE;
    end

    if (item.tick) begin
      hold_nxt = hold_r + 7'd1;
      if (phase_r == hlcc_pkg::PH_COOK) begin
        pwm_nxt   = pwm_r + 7'd1;
        presc_nxt = presc_r + 7'd1;
        if (presc_nxt >= regs.ticks_per_second) begin
          presc_nxt = '0;
          if (secs_r != 8'hFF) secs_nxt = secs_r + 8'd1;
        end
      end
    end

    if (phase_r == hlcc_pkg::PH_SELECT) begin
      if (latch_nxt == hlcc_pkg::PRESS_UP || latch_nxt == hlcc_pkg::PRESS_DOWN) begin
        if (hold_nxt >= regs.hold_repeat_ticks) begin
          hold_nxt = '0;
          if (latch_nxt == hlcc_pkg::PRESS_UP) begin
            if (level_r != hlcc_pkg::LEVEL_MAX) level_nxt = level_r + 3'd1;
          end else begin
            if (level_r != 3'd0) level_nxt = level_r - 3'd1;
          end
        end
      end else begin
        hold_nxt = '0;
      end
      if (latch_nxt == hlcc_pkg::PRESS_START) begin
        phase_nxt = hlcc_pkg::PH_COOK;
        latch_nxt = hlcc_pkg::PRESS_NONE;
      end
    end else begin
      if (level_r == 3'd0) begin
        lamps_nxt = 2'b10;
      end else if (level_r == hlcc_pkg::LEVEL_MAX) begin
        lamps_nxt = 2'b01;
      end else begin
        lamps_nxt = (pwm_nxt <= on_cnt) ? 2'b01 : 2'b10;
        if (pwm_nxt >= period) pwm_nxt = '0;
      end
      // Ending the cook clears everything but the button history.
      if (secs_nxt >= regs.cook_seconds || latch_nxt == hlcc_pkg::PRESS_STOP) begin
        latch_nxt = hlcc_pkg::PRESS_NONE;
        hold_nxt  = '0;
        level_nxt = '0;
        phase_nxt = hlcc_pkg::PH_SELECT;
        pwm_nxt   = '0;
        presc_nxt = '0;
        secs_nxt  = '0;
        lamps_nxt = '0;
      end
    end
  end

  always_comb begin
    result.level_leds       = level_nxt;
    result.heater_on        = lamps_nxt[0];
    result.heater_idle_lamp = lamps_nxt[1];
    result.cooking          = (phase_nxt == hlcc_pkg::PH_COOK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_btn_r <= '0;
      latch_r    <= hlcc_pkg::PRESS_NONE;
      hold_r     <= '0;
      level_r    <= '0;
      phase_r    <= hlcc_pkg::PH_SELECT;
      pwm_r      <= '0;
      presc_r    <= '0;
      secs_r     <= '0;
      lamps_r    <= '0;
    end else if (step) begin
      prev_btn_r <= prev_btn_nxt;
      latch_r    <= latch_nxt;
      hold_r     <= hold_nxt;
      level_r    <= level_nxt;
      phase_r    <= phase_nxt;
      pwm_r      <= pwm_nxt;
      presc_r    <= presc_nxt;
      secs_r     <= secs_nxt;
      lamps_r    <= lamps_nxt;
    end
  end

`ifndef SYNTH
  a_lamps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(lamps_r[0] && lamps_r[1]))
    else $error("heater and idle lamp lit together");
  a_lamps_off_selecting: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hlcc_pkg::PH_SELECT) |-> (lamps_r == 2'b00))
    else $error("lamp lit outside cooking");
  a_no_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(level_r) && $stable(phase_r) && $stable(secs_r))
    else $error("state changed without an item");
`endif

endmodule

### src/heater_level_cook_controller_core.sv
// Top level of the heater level cook controller: input stage, controller and result register.
// Each accepted item (four button levels and a tick flag) yields exactly one result item
// with the power level, the two lamp outputs and the cooking flag as they stand after that
// sample. Throughput is one item per clock while the result side does not stall; an accepted
// item is held in the input register while the controller update is computed, and the result
// register loads the result when the item advances.
// The whole update of the controller state happens as an item moves from the input register
// to the result register, so items are processed strictly in order. The three configuration
// registers reset to 16 s, 100 ticks and 100 ticks and should be written only while idle.
module heater_level_cook_controller_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hlcc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hlcc_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [hlcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hlcc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                in_valid_r, in_valid_nxt;
  hlcc_pkg::in_item_t  in_data_r;
  logic                out_valid_r, out_valid_nxt;
  hlcc_pkg::out_item_t out_data_r;
  logic                advance;
  logic                take;
  hlcc_pkg::cfg_regs_t regs;
  hlcc_pkg::out_item_t result;

  // The held item moves on when the result register is empty or being emptied.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  assign in_valid_nxt  = take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  hlcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  hlcc_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_data_r),
    .regs   (regs),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take)    in_data_r  <= in_data;
    if (advance) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_heater_only_cooking: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.heater_on |-> out_data_r.cooking)
    else $error("heater driven outside cooking");
  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_data_r))
    else $error("held input item lost or changed");
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result lost or changed");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the heater level cook controller core.
module testbench;

  localparam int HOLDOFF_CYCLES = 200;

  typedef struct packed {
    logic [3:0]          buttons;
    logic                tick;
    logic                typed;
    hlcc_pkg::out_item_t want;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  hlcc_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  hlcc_pkg::out_item_t             out_data;
  logic                            cfg_we = 1'b0;
  logic [hlcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hlcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  heater_level_cook_controller_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Controller state as the testbench expects it.
  hlcc_pkg::cfg_regs_t settings;
  logic [3:0]          prev_buttons;
  hlcc_pkg::press_t    latched;
  logic [6:0]          hold_ticks;
  logic [2:0]          level;
  hlcc_pkg::phase_t    mode;
  logic [6:0]          window_ticks;
  logic [6:0]          prescale;
  logic [7:0]          seconds;
  logic                heater;
  logic                idle_lamp;

  hlcc_pkg::out_item_t expected_levels [$];
  hlcc_pkg::out_item_t oldest;

  int failures = 0;
  int items_sent = 0;
  int results_checked = 0;
  int settings_applied = 0;
  int cooks_started = 0;
  int cooks_timed_out = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holdoff_asked = 0;
  int holdoff_served = 0;
  int holdoff_left = 0;

  dir_row_t directed_rows [$] = '{
    '{4'b0000, 1'b0, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}},
    '{4'b0001, 1'b1, 1'b1, '{3'd1, 1'b0, 1'b0, 1'b0}},
    '{4'b0001, 1'b1, 1'b0, '0},
    '{4'b0001, 1'b1, 1'b0, '0},
    '{4'b0001, 1'b1, 1'b0, '0},
    '{4'b0001, 1'b1, 1'b0, '0},
    '{4'b0001, 1'b1, 1'b0, '0},
    '{4'b0001, 1'b1, 1'b0, '0},
    '{4'b0001, 1'b1, 1'b1, '{3'd7, 1'b0, 1'b0, 1'b0}},
    '{4'b0000, 1'b1, 1'b0, '0},
    '{4'b0010, 1'b1, 1'b0, '0},
    '{4'b0011, 1'b1, 1'b0, '0},
    '{4'b1111, 1'b0, 1'b1, '{3'd7, 1'b0, 1'b0, 1'b1}},
    '{4'b1111, 1'b0, 1'b1, '{3'd7, 1'b1, 1'b0, 1'b1}},
    '{4'b0000, 1'b1, 1'b0, '0},
    '{4'b0100, 1'b0, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}},
    '{4'b1000, 1'b0, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b1}},
    '{4'b0000, 1'b1, 1'b1, '{3'd0, 1'b0, 1'b1, 1'b1}},
    '{4'b0000, 1'b1, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}},
    '{4'b0100, 1'b1, 1'b0, '0},
    '{4'b0001, 1'b1, 1'b0, '0},
    '{4'b0001, 1'b1, 1'b0, '0},
    '{4'b0001, 1'b1, 1'b0, '0},
    '{4'b1001, 1'b0, 1'b0, '0},
    '{4'b1011, 1'b1, 1'b0, '0},
    '{4'b1111, 1'b0, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}}
  };

  task automatic clear_cooker();
    latched = hlcc_pkg::PRESS_NONE;
    hold_ticks = '0;
    level = '0;
    mode = hlcc_pkg::PH_SELECT;
    window_ticks = '0;
    prescale = '0;
    seconds = '0;
    heater = 1'b0;
    idle_lamp = 1'b0;
  endtask

  // Advances the expected controller state by one sample and gives the lamps after it.
  task automatic advance_cooker(input logic [3:0] buttons, input logic tick,
                                output hlcc_pkg::out_item_t res);
    logic [3:0] fresh;
    logic [6:0] on_ticks;
    logic [6:0] period;
    fresh = (buttons ^ prev_buttons) & buttons;
    if (buttons != prev_buttons) begin
      if (fresh[3]) latched = hlcc_pkg::PRESS_START;
      else if (fresh[2]) latched = hlcc_pkg::PRESS_STOP;
      else if (fresh[1]) latched = hlcc_pkg::PRESS_DOWN;
      else if (fresh[0]) latched = hlcc_pkg::PRESS_UP;
      else latched = hlcc_pkg::PRESS_NONE;
      prev_buttons = buttons;
    end

    if (tick) begin
      hold_ticks = hold_ticks + 7'd1;
      if (mode == hlcc_pkg::PH_COOK) begin
        window_ticks = window_ticks + 7'd1;
        prescale = prescale + 7'd1;
        if (prescale >= settings.ticks_per_second) begin
          prescale = '0;
          if (seconds != 8'd255) seconds = seconds + 8'd1;
        end
      end
    end

    if (mode == hlcc_pkg::PH_SELECT) begin
      if (latched == hlcc_pkg::PRESS_UP || latched == hlcc_pkg::PRESS_DOWN) begin
        if (hold_ticks >= settings.hold_repeat_ticks) begin
          hold_ticks = '0;
          if (latched == hlcc_pkg::PRESS_UP) begin
            if (level != hlcc_pkg::LEVEL_MAX) level = level + 3'd1;
          end else if (level != 3'd0) begin
            level = level - 3'd1;
          end
        end
      end else begin
        hold_ticks = '0;
      end
      if (latched == hlcc_pkg::PRESS_START) begin
        mode = hlcc_pkg::PH_COOK;
        latched = hlcc_pkg::PRESS_NONE;
        cooks_started++;
      end
    end else begin
      case (level)
        3'd1:    begin on_ticks = 7'd10; period = 7'd100; end
        3'd2:    begin on_ticks = 7'd20; period = 7'd100; end
        3'd3:    begin on_ticks = 7'd40; period = 7'd100; end
        3'd4:    begin on_ticks = 7'd25; period = 7'd50; end
        3'd5:    begin on_ticks = 7'd35; period = 7'd50; end
        3'd6:    begin on_ticks = 7'd45; period = 7'd50; end
        default: begin on_ticks = 7'd0; period = 7'd0; end
      endcase
      if (level == 3'd0) begin
        heater = 1'b0;
        idle_lamp = 1'b1;
      end else if (level == hlcc_pkg::LEVEL_MAX) begin
        heater = 1'b1;
        idle_lamp = 1'b0;
      end else begin
        heater = (window_ticks <= on_ticks);
        idle_lamp = !heater;
        if (window_ticks >= period) window_ticks = '0;
      end
      if (seconds >= settings.cook_seconds || latched == hlcc_pkg::PRESS_STOP) begin
        if (latched != hlcc_pkg::PRESS_STOP) cooks_timed_out++;
        clear_cooker();
      end
    end

    res.level_leds = level;
    res.heater_on = heater;
    res.heater_idle_lamp = idle_lamp;
    res.cooking = (mode == hlcc_pkg::PH_COOK);
  endtask

  // Offers one item and, once it is taken, queues what it should produce.
  task automatic send_item(input logic [3:0] buttons, input logic tick,
                           input logic typed = 1'b0,
                           input hlcc_pkg::out_item_t want = '0);
    hlcc_pkg::out_item_t res;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{buttons_pressed: buttons, tick: tick};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_cooker(buttons, tick, res);
    expected_levels.push_back(typed ? want : res);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [hlcc_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == hlcc_pkg::CFG_COOK_SECONDS) settings.cook_seconds = value;
    else if (idx == hlcc_pkg::CFG_HOLD_REPEAT_TICKS) settings.hold_repeat_ticks = value[6:0];
    else if (idx == hlcc_pkg::CFG_TICKS_PER_SECOND) settings.ticks_per_second = value[6:0];
  endtask

  task automatic apply_settings(input logic [7:0] cook, input logic [7:0] hold,
                                input logic [7:0] tps);
    drain();
    write_reg(hlcc_pkg::CFG_COOK_SECONDS, cook);
    write_reg(hlcc_pkg::CFG_HOLD_REPEAT_TICKS, hold);
    write_reg(hlcc_pkg::CFG_TICKS_PER_SECOND, tps);
    settings_applied++;
  endtask

  // One user session: pick a level by holding up or down, start, cook, maybe stop.
  // Some sessions are plain button noise instead.
  task automatic run_session();
    logic [3:0] held;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6))
        send_item(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      return;
    end
    repeat ($urandom_range(0, 4)) begin
      send_item(4'b0000, 1'($urandom_range(0, 1)));
      held = ($urandom_range(0, 3) == 0) ? 4'b0010 : 4'b0001;
      repeat ($urandom_range(1, 12)) send_item(held, $urandom_range(0, 3) != 0);
    end
    send_item(4'b1000 | 4'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    // While cooking, up, down and start only latch.
    repeat ($urandom_range(1, 40))
      send_item(4'($urandom_range(0, 15)) & 4'b1011, $urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) != 0) begin
      send_item(4'b0000, 1'b0);
      send_item(4'b0100 | 4'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        $error("result arrived with no item outstanding");
        failures++;
      end else begin
        oldest = expected_levels.pop_front();
        compare_field("level_leds", 8'(oldest.level_leds), 8'(out_data.level_leds));
        compare_field("heater_on", 8'(oldest.heater_on), 8'(out_data.heater_on));
        compare_field("heater_idle_lamp", 8'(oldest.heater_idle_lamp),
                      8'(out_data.heater_idle_lamp));
        compare_field("cooking", 8'(oldest.cooking), 8'(out_data.cooking));
        results_checked++;
      end
    end
  end

  // Result side back-pressure, with a single long hold-off that fills the block.
  always @(negedge clk) begin
    if (holdoff_served != holdoff_asked) begin
      holdoff_served = holdoff_asked;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    int target;
    settings = '{cook_seconds: hlcc_pkg::COOK_SECONDS_RST,
                 hold_repeat_ticks: hlcc_pkg::HOLD_REPEAT_TICKS_RST,
                 ticks_per_second: hlcc_pkg::TICKS_PER_SECOND_RST};
    prev_buttons = '0;
    clear_cooker();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    apply_settings(8'd2, 8'd1, 8'd1);
    foreach (directed_rows[i])
      send_item(directed_rows[i].buttons, directed_rows[i].tick,
                directed_rows[i].typed, directed_rows[i].want);

    for (int seg = 0; seg < 7; seg++) begin
      case (seg)
        0: apply_settings(8'd1, 8'd1, 8'd1);
        1: apply_settings(8'd255, 8'd127, 8'd127);
        2: apply_settings(8'd3, 8'd2, 8'd2);
        3: apply_settings(8'(hlcc_pkg::COOK_SECONDS_RST), 8'(hlcc_pkg::HOLD_REPEAT_TICKS_RST),
                          8'(hlcc_pkg::TICKS_PER_SECOND_RST));
        6: apply_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 127)),
                          8'($urandom_range(1, 127)));
        default: apply_settings(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                                8'($urandom_range(1, 6)));
      endcase
      case (seg % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 51; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 51; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      if (seg == 4) holdoff_asked++;
      target = items_sent + 45;
      while (items_sent < target) run_session();
    end

    drain();
    $display("Sent %0d items under %0d register settings; %0d results checked.",
             items_sent, settings_applied, results_checked);
    $display("Cooking entered %0d times, %0d of them ended by the cook timer.",
             cooks_started, cooks_timed_out);
    if (failures == 0 && expected_levels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
src/hlcc_pkg.sv
src/hlcc_cfg.sv
src/hlcc_engine.sv
src/heater_level_cook_controller_core.sv
verif/testbench.sv
